// ----- hw/rtl/rsa_pkg.sv -----
// Shared types and constants of the reference-counted slot allocator.
// No dependencies; used by rsa_key_cam, rsa_free_stack and refcounted_slot_allocator.
package rsa_pkg;

  // Field widths
  localparam int SLOT_W = 10;
  localparam int CAP_W  = 11;
  localparam int KEY_W  = 64;
  localparam int REFS_W = 16;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  // Default sizes
  localparam int MAX_SLOTS_DEF   = 1024;
  localparam int KEY_ENTRIES_DEF = 64;

  // Register reset values and limits
  localparam logic [CAP_W-1:0]  START_CAP_RST  = 11'd16;
  localparam logic [CAP_W-1:0]  SLOT_LIMIT_RST = 11'd1024;
  localparam logic [REFS_W-1:0] REFS_MAX       = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_GRANT   = 2'd2,
    OP_FREE    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_BAD_INDEX  = 3'd5
  } status_t;

  typedef enum logic {
    CFG_START_CAP  = 1'b0,
    CFG_SLOT_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CAM_NOP    = 2'd0,
    CAM_INSERT = 2'd1,
    CAM_INC    = 2'd2,
    CAM_DEC    = 2'd3
  } cam_op_t;

  // Update command into the key table
  typedef struct packed {
    cam_op_t             op;
    logic [SLOT_W-1:0]   slot;
  } cam_cmd_t;

  // Lookup result out of the key table
  typedef struct packed {
    logic                hit;
    logic [REFS_W-1:0]   refs;
    logic [SLOT_W-1:0]   slot;
    logic                room;
  } cam_look_t;

  // Push/pop command into the free stack
  typedef struct packed {
    logic                push;
    logic                pop;
    logic [SLOT_W-1:0]   slot;
  } stack_cmd_t;

endpackage

// ----- hw/rtl/rsa_key_cam.sv -----
// Key table: content-addressed rows holding key, reference count and slot.
// Depends on rsa_pkg.
module rsa_key_cam #(
  parameter int KEY_ENTRIES = rsa_pkg::KEY_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rsa_pkg::KEY_W-1:0] key,
  input  rsa_pkg::cam_cmd_t         cmd,
  output rsa_pkg::cam_look_t        look
);

  logic [KEY_ENTRIES-1:0]            valid_r;
  logic [rsa_pkg::KEY_W-1:0]         value_r [KEY_ENTRIES];
  logic [rsa_pkg::REFS_W-1:0]        refs_r  [KEY_ENTRIES];
  logic [rsa_pkg::SLOT_W-1:0]        slot_r  [KEY_ENTRIES];

  logic [KEY_ENTRIES-1:0]            match;
  logic [KEY_ENTRIES-1:0]            free_sel;

  // Parallel compare against every valid row
  always_comb begin
    for (int i = 0; i < KEY_ENTRIES; i++) begin
      match[i] = valid_r[i] && (value_r[i] == key);
    end
  end

  // Lowest empty row, one-hot
  assign free_sel = ~valid_r & (valid_r + KEY_ENTRIES'(1));

  // Read out the matching row (keys are unique among valid rows)
  always_comb begin
    look.hit  = |match;
    look.room = ~&valid_r;
    look.refs = '0;
    look.slot = '0;
    for (int i = 0; i < KEY_ENTRIES; i++) begin
      if (match[i]) begin
        look.refs = look.refs | refs_r[i];
        look.slot = look.slot | slot_r[i];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      case (cmd.op)
        rsa_pkg::CAM_INSERT: valid_r <= valid_r | free_sel;
        rsa_pkg::CAM_DEC: begin
          if (look.refs == rsa_pkg::REFS_W'(1)) valid_r <= valid_r & ~match;
        end
        default: ;
      endcase
    end
  end

  // Row contents
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEY_ENTRIES; i++) begin
      case (cmd.op)
        rsa_pkg::CAM_INSERT: begin
          if (free_sel[i]) begin
            value_r[i] <= key;
            refs_r[i]  <= rsa_pkg::REFS_W'(1);
            slot_r[i]  <= cmd.slot;
          end
        end
        rsa_pkg::CAM_INC: if (match[i]) refs_r[i] <= refs_r[i] + rsa_pkg::REFS_W'(1);
        rsa_pkg::CAM_DEC: if (match[i]) refs_r[i] <= refs_r[i] - rsa_pkg::REFS_W'(1);
        default: ;
      endcase
    end
  end

  // A key never sits in two valid rows
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(match))
    else $error("key matches more than one row");

  // Insert only when a row is free and the key is absent
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == rsa_pkg::CAM_INSERT |-> look.room && !look.hit)
    else $error("insert without room or on existing key");

  // Count changes only on a hit
  a_update_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rsa_pkg::CAM_INC || cmd.op == rsa_pkg::CAM_DEC) |-> look.hit)
    else $error("count update without hit");

endmodule

// ----- hw/rtl/rsa_free_stack.sv -----
// LIFO of freed slots: top entry in a register, the rest in a memory whose
// next entry is prefetched into a read register. Depends on rsa_pkg.
module rsa_free_stack #(
  parameter  int MAX_SLOTS = rsa_pkg::MAX_SLOTS_DEF,
  localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsa_pkg::stack_cmd_t        cmd,
  output logic [rsa_pkg::SLOT_W-1:0] top,
  output logic [DEPTH_W-1:0]         depth
);

  localparam int AW = $clog2(MAX_SLOTS);

  logic [rsa_pkg::SLOT_W-1:0] mem [MAX_SLOTS];
  logic [rsa_pkg::SLOT_W-1:0] top_r, top_nxt;
  logic [rsa_pkg::SLOT_W-1:0] rd_r;
  logic [DEPTH_W-1:0]         depth_r, depth_nxt;
  logic [DEPTH_W-1:0]         depth_m1, rd_full;
  logic                       push_ok, wr_en;
  logic [AW-1:0]              wr_addr, rd_addr;

  // Push onto a full stack is dropped
  assign push_ok  = cmd.push && (depth_r != DEPTH_W'(MAX_SLOTS));
  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign wr_en    = push_ok && (depth_r != '0);
  assign wr_addr  = depth_m1[AW-1:0];

  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (push_ok) begin
      depth_nxt = depth_r + DEPTH_W'(1);
      top_nxt   = cmd.slot;
    end else if (cmd.pop) begin
      depth_nxt = depth_m1;
      top_nxt   = rd_r;
    end
  end

  // Prefetch the entry just below the next top
  assign rd_full = depth_nxt - DEPTH_W'(2);
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Memory with forwarding of a same-cycle write to the prefetch
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (wr_en) mem[wr_addr] <= top_r;
    if (wr_en && (wr_addr == rd_addr)) rd_r <= top_r;
    else rd_r <= mem[rd_addr];
  end

  assign top   = top_r;
  assign depth = depth_r;

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> depth_r != '0)
    else $error("pop from empty stack");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n) !(cmd.push && cmd.pop))
    else $error("push and pop together");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= MAX_SLOTS)
    else $error("stack depth beyond size");

endmodule

// ----- hw/rtl/refcounted_slot_allocator.sv -----
// Top level of the reference-counted slot allocator.
// Depends on rsa_pkg, rsa_key_cam and rsa_free_stack.
//
// Takes one request per clock cycle while the receiver takes results; each result is
// offered from the result register that the input register feeds, and an unread
// result blocks the pipe only once both registers are full. All work for a request is
// one key compare across the table plus at most one push or pop of the free stack;
// the stack keeps its top in a register and prefetches the entry below it from its
// memory, so back-to-back pops never wait on the memory. No clearing pass runs after
// reset: the stack is tracked by its depth and the key table by per-row valid bits.
// Configuration writes are always ready.
module refcounted_slot_allocator #(
  parameter int MAX_SLOTS   = rsa_pkg::MAX_SLOTS_DEF,
  parameter int KEY_ENTRIES = rsa_pkg::KEY_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [rsa_pkg::CAP_W-1:0]   cfg_data,
  // requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rsa_pkg::OP_W-1:0]    in_opcode,
  input  logic [rsa_pkg::KEY_W-1:0]   in_entry_key,
  input  logic [rsa_pkg::SLOT_W-1:0]  in_free_slot,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rsa_pkg::SLOT_W-1:0]  out_slot_index,
  output logic [rsa_pkg::STAT_W-1:0]  out_status,
  output logic [rsa_pkg::REFS_W-1:0]  out_references,
  output logic [rsa_pkg::CAP_W-1:0]   out_capacity_now,
  output logic                        out_grew
);

  localparam int DEPTH_W = $clog2(MAX_SLOTS + 1);
  localparam int CAP_W   = rsa_pkg::CAP_W;
  localparam int SLOT_W  = rsa_pkg::SLOT_W;
  localparam int NCAP_W  = CAP_W + 1;

  // Highest set bit of v as a one-hot mask
  function automatic logic [NCAP_W-1:0] msb_mask(input logic [NCAP_W-1:0] v);
    logic [NCAP_W-1:0] m;
    m = '0;
    for (int b = 0; b < NCAP_W; b++) begin
      if (v[b]) m = NCAP_W'(1) << b;
    end
    return m;
  endfunction

  // Configuration registers
  logic [CAP_W-1:0] start_r, limit_r;

  // Input register
  logic                          inv_r;
  rsa_pkg::op_t                  op_r;
  logic [rsa_pkg::KEY_W-1:0]     key_r;
  logic [SLOT_W-1:0]             fs_r;

  // Allocator state
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [CAP_W-1:0] fresh_r, fresh_nxt;

  // Result register
  logic                          outv_r;
  logic [SLOT_W-1:0]             slot_q;
  rsa_pkg::status_t              status_q;
  logic [rsa_pkg::REFS_W-1:0]    refs_q;
  logic [CAP_W-1:0]              capnow_q;
  logic                          grew_q;

  logic fire;

  rsa_pkg::cam_look_t  look;
  rsa_pkg::cam_cmd_t   cam_c, cam_cmd;
  rsa_pkg::stack_cmd_t stk_c, stk_cmd;
  logic [SLOT_W-1:0]   stk_top;
  logic [DEPTH_W-1:0]  stk_depth;

  // Handshakes
  assign fire      = inv_r && (!outv_r || out_ready);
  assign in_ready  = !inv_r || fire;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= rsa_pkg::START_CAP_RST;
      limit_r <= rsa_pkg::SLOT_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (rsa_pkg::cfg_idx_t'(cfg_index))
        rsa_pkg::CFG_START_CAP:  start_r <= cfg_data;
        rsa_pkg::CFG_SLOT_LIMIT: limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ready) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= rsa_pkg::op_t'(in_opcode);
      key_r <= in_entry_key;
      fs_r  <= in_free_slot;
    end
  end

  // Growth target: start capacity first, then next power of two, capped
  logic [CAP_W-1:0]  lim_eff, start1;
  logic [NCAP_W-1:0] cap_p1, base, newcap;
  logic              grow_ok;

  always_comb begin
    if (limit_r == '0) lim_eff = CAP_W'(1);
    else if (32'(limit_r) > MAX_SLOTS) lim_eff = CAP_W'(MAX_SLOTS);
    else lim_eff = limit_r;
    start1 = (start_r == '0) ? CAP_W'(1) : start_r;
    cap_p1 = {1'b0, cap_r} + NCAP_W'(1);
    base   = (cap_r == '0) ? {1'b0, start1} : (msb_mask(cap_p1) << 1);
    newcap = (base > {1'b0, lim_eff}) ? {1'b0, lim_eff} : base;
    grow_ok = newcap > {1'b0, cap_r};
  end

  // Slot grant: free stack first, then fresh slots, growing when needed
  logic              g_ok, g_pop, g_grew;
  logic [SLOT_W-1:0] g_slot;
  logic [CAP_W-1:0]  g_cap, g_fresh;

  always_comb begin
    g_ok    = 1'b1;
    g_pop   = 1'b0;
    g_grew  = 1'b0;
    g_slot  = fresh_r[SLOT_W-1:0];
    g_cap   = cap_r;
    g_fresh = fresh_r + CAP_W'(1);
    if (stk_depth != '0) begin
      g_pop   = 1'b1;
      g_slot  = stk_top;
      g_fresh = fresh_r;
    end else if (fresh_r >= cap_r) begin
      if (grow_ok) begin
        g_cap  = newcap[CAP_W-1:0];
        g_grew = 1'b1;
      end else begin
        g_ok    = 1'b0;
        g_fresh = fresh_r;
      end
    end
  end

  // Request decode and result
  logic [SLOT_W-1:0]          res_slot;
  rsa_pkg::status_t           res_status;
  logic [rsa_pkg::REFS_W-1:0] res_refs;
  logic                       res_grew;

  always_comb begin
    res_slot   = '0;
    res_status = rsa_pkg::ST_OK;
    res_refs   = '0;
    res_grew   = 1'b0;
    cap_nxt    = cap_r;
    fresh_nxt  = fresh_r;
    cam_c      = '{op: rsa_pkg::CAM_NOP, slot: '0};
    stk_c      = '{push: 1'b0, pop: 1'b0, slot: '0};
    case (op_r)
      rsa_pkg::OP_ADD: begin
        if (look.hit) begin
          res_slot = look.slot;
          if (look.refs == rsa_pkg::REFS_MAX) begin
            res_status = rsa_pkg::ST_OVERFLOW;
            res_refs   = rsa_pkg::REFS_MAX;
          end else begin
            res_refs  = look.refs + rsa_pkg::REFS_W'(1);
            cam_c.op  = rsa_pkg::CAM_INC;
          end
        end else if (!look.room) begin
          res_status = rsa_pkg::ST_TABLE_FULL;
        end else if (!g_ok) begin
          res_status = rsa_pkg::ST_EXHAUSTED;
        end else begin
          res_slot   = g_slot;
          res_refs   = rsa_pkg::REFS_W'(1);
          res_grew   = g_grew;
          cap_nxt    = g_cap;
          fresh_nxt  = g_fresh;
          stk_c.pop  = g_pop;
          cam_c.op   = rsa_pkg::CAM_INSERT;
          cam_c.slot = g_slot;
        end
      end
      rsa_pkg::OP_RELEASE: begin
        if (!look.hit) begin
          res_status = rsa_pkg::ST_UNKNOWN;
        end else begin
          res_slot = look.slot;
          res_refs = look.refs - rsa_pkg::REFS_W'(1);
          cam_c.op = rsa_pkg::CAM_DEC;
          // last reference gone: slot goes back on the stack
          if (look.refs == rsa_pkg::REFS_W'(1)) begin
            stk_c.push = 1'b1;
            stk_c.slot = look.slot;
          end
        end
      end
      rsa_pkg::OP_GRANT: begin
        if (!g_ok) begin
          res_status = rsa_pkg::ST_EXHAUSTED;
        end else begin
          res_slot  = g_slot;
          res_grew  = g_grew;
          cap_nxt   = g_cap;
          fresh_nxt = g_fresh;
          stk_c.pop = g_pop;
        end
      end
      rsa_pkg::OP_FREE: begin
        res_slot = fs_r;
        if (CAP_W'(fs_r) >= cap_r) begin
          res_status = rsa_pkg::ST_BAD_INDEX;
        end else begin
          stk_c.push = 1'b1;
          stk_c.slot = fs_r;
        end
      end
      default: ;
    endcase
  end

  // Commands take effect only with a transfer into the result register
  assign cam_cmd = fire ? cam_c : '{op: rsa_pkg::CAM_NOP, slot: '0};
  assign stk_cmd = fire ? stk_c : '{push: 1'b0, pop: 1'b0, slot: '0};

  rsa_key_cam #(
    .KEY_ENTRIES (KEY_ENTRIES)
  ) u_cam (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (key_r),
    .cmd   (cam_cmd),
    .look  (look)
  );

  rsa_free_stack #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .top   (stk_top),
    .depth (stk_depth)
  );

  // Capacity and fresh counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      fresh_r <= '0;
    end else if (fire) begin
      cap_r   <= cap_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (fire) begin
      outv_r <= 1'b1;
    end else if (out_ready) begin
      outv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot_q   <= res_slot;
      status_q <= res_status;
      refs_q   <= res_refs;
      capnow_q <= cap_nxt;
      grew_q   <= res_grew;
    end
  end

  assign out_valid        = outv_r;
  assign out_slot_index   = slot_q;
  assign out_status       = status_q;
  assign out_references   = refs_q;
  assign out_capacity_now = capnow_q;
  assign out_grew         = grew_q;

  a_grew_ok: assert property (@(posedge clk) disable iff (!rst_n)
    outv_r && grew_q |-> status_q == rsa_pkg::ST_OK)
    else $error("growth reported on a failed request");

  a_cap_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cap_r >= $past(cap_r))
    else $error("capacity shrank");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n) fresh_r <= cap_r)
    else $error("fresh counter beyond capacity");

  a_grow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_grew |-> stk_depth == '0)
    else $error("capacity grew while free slots remained");

endmodule

// ----- verif/refcounted_slot_allocator_tb.sv -----
// Self-checking testbench for refcounted_slot_allocator: directed and random requests,
// register writes between phases, and a predictor of slot, key and capacity state.
// Depends on rsa_pkg and the refcounted_slot_allocator RTL.
module refcounted_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS   = rsa_pkg::MAX_SLOTS_DEF;
  localparam int KEY_ENTRIES = rsa_pkg::KEY_ENTRIES_DEF;
  localparam int KEY_W       = rsa_pkg::KEY_W;
  localparam int SLOT_W      = rsa_pkg::SLOT_W;
  localparam int CAP_W       = rsa_pkg::CAP_W;
  localparam int REFS_W      = rsa_pkg::REFS_W;
  localparam int OP_W        = rsa_pkg::OP_W;
  localparam int STAT_W      = rsa_pkg::STAT_W;
  localparam int KEY_POOL    = 72;   // a little over the table size so it can fill

  typedef struct {
    rsa_pkg::op_t      op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] fs;
  } request_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    rsa_pkg::status_t  status;
    logic [REFS_W-1:0] refs;
    logic [CAP_W-1:0]  cap;
    logic              grew;
  } alloc_result_t;

  // DUT ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [CAP_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_opcode = '0;
  logic [KEY_W-1:0]  in_entry_key = '0;
  logic [SLOT_W-1:0] in_free_slot = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_slot_index;
  logic [STAT_W-1:0] out_status;
  logic [REFS_W-1:0] out_references;
  logic [CAP_W-1:0]  out_capacity_now;
  logic              out_grew;

  // Stimulus and scoreboard state
  request_t      pending[$];
  alloc_result_t results_due[$];
  int            n_offered = 0;
  int            n_taken = 0;
  int            n_errors = 0;
  int            src_idle_pct = 0;
  int            sink_idle_pct = 0;
  bit            hold_go = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;
  logic [KEY_W-1:0] key_pool[KEY_POOL];

  // Predictor state
  int               m_stack[MAX_SLOTS];
  int               m_depth = 0;
  int               m_fresh = 0;
  int               m_cap = 0;
  int               m_start = int'(rsa_pkg::START_CAP_RST);
  int               m_limit = int'(rsa_pkg::SLOT_LIMIT_RST);
  bit               m_kvalid[KEY_ENTRIES];
  logic [KEY_W-1:0] m_kkey[KEY_ENTRIES];
  int               m_krefs[KEY_ENTRIES];
  int               m_kslot[KEY_ENTRIES];

  refcounted_slot_allocator dut (.*);

  always #5 clk = ~clk;

  // Free stack push; a push onto a full stack is lost
  function automatic void push_free(int s);
    if (m_depth < MAX_SLOTS) begin
      m_stack[m_depth] = s;
      m_depth++;
    end
  endfunction

  // Pop a freed slot, else hand out a fresh one, growing capacity if needed
  function automatic bit take_slot(output int slot, output bit grew);
    int lim, newcap, v, lg;
    grew = 1'b0;
    slot = 0;
    lim = m_limit;
    if (lim < 1) lim = 1;
    if (lim > MAX_SLOTS) lim = MAX_SLOTS;
    if (m_depth > 0) begin
      m_depth--;
      slot = m_stack[m_depth];
      return 1'b1;
    end
    if (m_fresh >= m_cap) begin
      if (m_cap == 0) begin
        newcap = (m_start < 1) ? 1 : m_start;
      end else begin
        v = m_cap + 1;
        lg = 0;
        while (v > 1) begin
          v = v >> 1;
          lg++;
        end
        newcap = 2 << lg;
      end
      if (newcap > lim) newcap = lim;
      // growth impossible: fail and leave everything as is
      if (newcap <= m_cap) return 1'b0;
      m_cap = newcap;
      grew = 1'b1;
    end
    slot = m_fresh;
    m_fresh++;
    return 1'b1;
  endfunction

  // Expected result of one request; updates the predictor state
  function automatic alloc_result_t predict_request(rsa_pkg::op_t op, logic [KEY_W-1:0] key,
                                                    logic [SLOT_W-1:0] fs);
    alloc_result_t r;
    int hit, room, slot;
    bit grew;
    slot = 0;
    grew = 1'b0;
    r.status = rsa_pkg::ST_OK;
    r.refs = '0;
    hit = -1;
    room = -1;
    for (int i = 0; i < KEY_ENTRIES; i++) begin
      if (m_kvalid[i] && m_kkey[i] == key && hit < 0) hit = i;
      if (!m_kvalid[i] && room < 0) room = i;
    end
    case (op)
      rsa_pkg::OP_ADD: begin
        if (hit >= 0) begin
          slot = m_kslot[hit];
          if (m_krefs[hit] >= int'(rsa_pkg::REFS_MAX)) begin
            r.status = rsa_pkg::ST_OVERFLOW;
            r.refs = rsa_pkg::REFS_MAX;
          end else begin
            m_krefs[hit]++;
            r.refs = REFS_W'(m_krefs[hit]);
          end
        end else if (room < 0) begin
          r.status = rsa_pkg::ST_TABLE_FULL;
        end else if (!take_slot(slot, grew)) begin
          r.status = rsa_pkg::ST_EXHAUSTED;
          slot = 0;
        end else begin
          // new key goes to the lowest free table row
          m_kvalid[room] = 1'b1;
          m_kkey[room] = key;
          m_krefs[room] = 1;
          m_kslot[room] = slot;
          r.refs = REFS_W'(1);
        end
      end
      rsa_pkg::OP_RELEASE: begin
        if (hit < 0) begin
          r.status = rsa_pkg::ST_UNKNOWN;
        end else begin
          slot = m_kslot[hit];
          if (m_krefs[hit] > 0) m_krefs[hit]--;
          r.refs = REFS_W'(m_krefs[hit]);
          if (m_krefs[hit] == 0) begin
            push_free(slot);
            m_kvalid[hit] = 1'b0;
          end
        end
      end
      rsa_pkg::OP_GRANT: begin
        if (!take_slot(slot, grew)) begin
          r.status = rsa_pkg::ST_EXHAUSTED;
          slot = 0;
        end
      end
      default: begin
        slot = int'(fs);
        if (int'(fs) >= m_cap) r.status = rsa_pkg::ST_BAD_INDEX;
        else push_free(int'(fs));
      end
    endcase
    r.slot = SLOT_W'(slot);
    r.cap = CAP_W'(m_cap);
    r.grew = grew;
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      n_errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Request driver: next pending item once the current one has transferred
  always @(negedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (n_taken == n_offered) begin
      if (pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending.pop_front();
        in_valid <= 1'b1;
        in_opcode <= nxt.op;
        in_entry_key <= nxt.key;
        in_free_slot <= nxt.fs;
        n_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 200;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: register writes, result checks, predictions on input transfers
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rsa_pkg::CFG_START_CAP) m_start = int'(cfg_data);
        else m_limit = int'(cfg_data);
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          n_errors++;
          $error("result transfer with none expected");
        end else begin
          want = results_due.pop_front();
          check_field("slot_index", 64'(want.slot), 64'(out_slot_index));
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("references", 64'(want.refs), 64'(out_references));
          check_field("capacity_now", 64'(want.cap), 64'(out_capacity_now));
          check_field("grew", 64'(want.grew), 64'(out_grew));
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(predict_request(rsa_pkg::op_t'(in_opcode), in_entry_key,
                                              in_free_slot));
        n_taken++;
      end
    end
  end

  task automatic queue_req(rsa_pkg::op_t op, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] fs);
    request_t rq;
    rq.op = op;
    rq.key = key;
    rq.fs = fs;
    pending.push_back(rq);
  endtask

  // Register write on the config channel; only called while the block is idle
  task automatic write_reg(rsa_pkg::cfg_idx_t idx, logic [CAP_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every queued item has produced its result
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || n_taken != n_offered || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Mixed traffic: keys mostly from the pool, frees mostly inside the span
  task automatic queue_random(int count, int w_add, int w_rel, int w_grant, int span);
    request_t rq;
    int pick;
    repeat (count) begin
      rq.key = {$urandom, $urandom};
      rq.fs = SLOT_W'($urandom_range(MAX_SLOTS - 1));
      pick = $urandom_range(99);
      if (pick < w_add) begin
        rq.op = rsa_pkg::OP_ADD;
        if ($urandom_range(9) != 0) rq.key = key_pool[$urandom_range(KEY_POOL - 1)];
      end else if (pick < w_add + w_rel) begin
        rq.op = rsa_pkg::OP_RELEASE;
        if ($urandom_range(99) < 85) rq.key = key_pool[$urandom_range(KEY_POOL - 1)];
      end else if (pick < w_add + w_rel + w_grant) begin
        rq.op = rsa_pkg::OP_GRANT;
      end else begin
        rq.op = rsa_pkg::OP_FREE;
        if ($urandom_range(99) < 85) rq.fs = SLOT_W'($urandom_range(span - 1));
      end
      pending.push_back(rq);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] ones, hot_key;
    ones = '1;
    hot_key = {$urandom, $urandom};
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    src_idle_pct = 15;
    sink_idle_pct = 57;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Both registers at zero: clamped to a capacity of one
    write_reg(rsa_pkg::CFG_START_CAP, '0);
    write_reg(rsa_pkg::CFG_SLOT_LIMIT, '0);
    queue_req(rsa_pkg::OP_GRANT, ones, '1);          // first growth
    queue_req(rsa_pkg::OP_GRANT, '0, '0);            // growth impossible
    queue_req(rsa_pkg::OP_FREE, ones, '1);           // bad index
    queue_req(rsa_pkg::OP_FREE, '0, '0);
    queue_req(rsa_pkg::OP_ADD, '0, '1);              // miss, reuses freed slot
    queue_req(rsa_pkg::OP_ADD, '0, '0);              // hit
    queue_req(rsa_pkg::OP_ADD, ones, '0);            // miss with no slot left
    queue_req(rsa_pkg::OP_RELEASE, ones, '1);        // unknown key
    queue_req(rsa_pkg::OP_RELEASE, '0, '0);
    queue_req(rsa_pkg::OP_RELEASE, '0, '1);          // count reaches zero, slot freed
    queue_req(rsa_pkg::OP_GRANT, '0, '0);
    wait_idle();

    // Limit above the slot count, clamped to the maximum
    write_reg(rsa_pkg::CFG_SLOT_LIMIT, '1);
    repeat (5) queue_req(rsa_pkg::OP_GRANT, {$urandom, $urandom}, SLOT_W'($urandom));
    queue_req(rsa_pkg::OP_FREE, '0, '1);
    queue_req(rsa_pkg::OP_FREE, ones, 10'd3);
    queue_req(rsa_pkg::OP_ADD, ones, '1);
    queue_req(rsa_pkg::OP_ADD, ones, '0);
    queue_req(rsa_pkg::OP_RELEASE, {$urandom, $urandom}, '1);
    wait_idle();

    // Several references on one key, then release one
    repeat (6) queue_req(rsa_pkg::OP_ADD, hot_key, SLOT_W'($urandom));
    queue_req(rsa_pkg::OP_RELEASE, hot_key, '0);
    queue_req(rsa_pkg::OP_ADD, hot_key, '0);
    queue_req(rsa_pkg::OP_ADD, hot_key, '1);
    wait_idle();

    // Small limit, with the long receiver hold-off
    write_reg(rsa_pkg::CFG_START_CAP, '1);
    write_reg(rsa_pkg::CFG_SLOT_LIMIT, 11'd40);
    hold_go = 1'b1;
    queue_random(150, 45, 20, 20, 48);
    wait_idle();

    src_idle_pct = 57;
    sink_idle_pct = 15;
    write_reg(rsa_pkg::CFG_START_CAP, 11'd1024);
    write_reg(rsa_pkg::CFG_SLOT_LIMIT, 11'd100);
    queue_random(100, 45, 15, 10, 128);
    wait_idle();

    // Limit below the present capacity: no further growth
    write_reg(rsa_pkg::CFG_SLOT_LIMIT, 11'd1);
    queue_random(80, 25, 25, 35, 128);
    wait_idle();

    write_reg(rsa_pkg::CFG_START_CAP, rsa_pkg::START_CAP_RST);
    write_reg(rsa_pkg::CFG_SLOT_LIMIT, rsa_pkg::SLOT_LIMIT_RST);
    queue_random(150, 40, 25, 20, 1024);
    wait_idle();

    // Overfill the free stack with raw frees, then mixed traffic
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (1040) queue_req(rsa_pkg::OP_FREE, {$urandom, $urandom},
                            SLOT_W'($urandom_range(m_cap - 1)));
    queue_random(60, 25, 25, 30, 1024);
    wait_idle();

    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
